/* rtl/core/olist_pkg.sv */
// Shared types and constants for the ordered list engine.
// No dependencies; used by olist_cell and ordered_list_engine.
package olist_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Count and position width inside the list (holds 0..CAPACITY)
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Field widths fixed by the stream format
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    // Width used when checking a request position against the count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STAT_W + 1 + VALUE_W + POS_W + POS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 3'd0,
        KIND_CONTAINS = 3'd1,
        KIND_GET_ELEM = 3'd2,
        KIND_GET_POS  = 3'd3,
        KIND_REPLACE  = 3'd4,
        KIND_REMOVE   = 3'd5
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_REPLACE = 2'd2,
        CELL_REMOVE  = 2'd3
    } cell_op_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t              op;
        logic [CNT_W-1:0]      target;  // 0-based position
        logic [CNT_W-1:0]      count;   // current entry count
        logic [DATA_WIDTH-1:0] value;
    } cell_cmd_t;

endpackage

/* rtl/core/olist_cell.sv */
// One list slot: holds an entry, shifts with its neighbors, compares and reads.
// Depends on olist_pkg.
module olist_cell
(
    input  logic                             clk,
    input  olist_pkg::cell_cmd_t             cmd,
    input  logic [olist_pkg::CNT_W-1:0]      cell_idx,   // tied to this slot's index
    input  logic [olist_pkg::DATA_WIDTH-1:0] left_entry,
    input  logic [olist_pkg::DATA_WIDTH-1:0] right_entry,
    input  logic [olist_pkg::CNT_W-1:0]      hit_in,     // 1-based hit so far, 0 none
    input  logic [olist_pkg::DATA_WIDTH-1:0] rd_in,
    output logic [olist_pkg::DATA_WIDTH-1:0] entry,
    output logic [olist_pkg::CNT_W-1:0]      hit_out,
    output logic [olist_pkg::DATA_WIDTH-1:0] rd_out
);

    logic [olist_pkg::DATA_WIDTH-1:0] entry_reg;
    logic [olist_pkg::DATA_WIDTH-1:0] entry_next;
    logic                             is_target;
    logic                             match;

    assign entry     = entry_reg;
    assign is_target = (cell_idx == cmd.target);
    assign match     = (cell_idx < cmd.count) && (entry_reg == cmd.value);

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            olist_pkg::CELL_INSERT:
            begin
                entry_next = (cell_idx == '0) ? cmd.value : left_entry;
            end
            olist_pkg::CELL_REPLACE:
            begin
                if (is_target)
                begin
                    entry_next = cmd.value;
                end
            end
            olist_pkg::CELL_REMOVE:
            begin
                if (cell_idx >= cmd.target)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // first hit wins as it ripples toward the back
    assign hit_out = (hit_in != '0) ? hit_in
                   : (match ? cell_idx + olist_pkg::CNT_W'(1) : '0);
    assign rd_out  = rd_in | (is_target ? entry_reg : '0);

endmodule

/* rtl/core/ordered_list_engine.sv */
// Top level of the ordered list engine: stream ports, count, result register.
// Depends on olist_pkg and olist_cell.

// The list lives in a row of CAPACITY identical cells, cell 0 being list
// position 1. Insert shifts every cell back by one, remove shifts cells from
// the removed position forward by one, replace writes one cell; searches
// compare all cells at once and the first hit ripples down the row. Each
// request is handled as it is accepted and its result lands in an output
// register, so a new request is taken every cycle while the result side
// keeps up (s_tready stays high while the output register is empty or being
// drained). The clock limit is set by the search path: 32-bit compare in
// every cell followed by the hit ripple through the row of cells. Requests
// with an unused kind change nothing; status ok, fields zero but length.
module ordered_list_engine
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [olist_pkg::S_TDATA_W-1:0] s_tdata,  // position[4:0], item_value[36:5], zero pad
    input  logic [olist_pkg::KIND_W-1:0]    s_tuser,  // kind[2:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [olist_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], found[2],
                                                      // read_value[34:3],
                                                      // found_position[39:35],
                                                      // list_length[44:40], zero pad
);

    localparam int C = olist_pkg::CAPACITY;
    localparam int W = olist_pkg::DATA_WIDTH;
    localparam int N = olist_pkg::CNT_W;

    // request fields
    logic [olist_pkg::POS_W-1:0]   req_pos;
    logic [olist_pkg::VALUE_W-1:0] req_value;
    logic [olist_pkg::KIND_W-1:0]  req_kind;
    logic                          accept;

    logic [N-1:0]                  count_reg;
    logic [N-1:0]                  count_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [olist_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [olist_pkg::M_TDATA_W-1:0] m_data_next;

    logic [olist_pkg::CMP_W-1:0]   pos_w;
    logic [olist_pkg::CMP_W-1:0]   cnt_w;
    logic                          pos_ok;
    logic                          full;
    olist_pkg::cell_cmd_t          cmd;

    // cell row wiring
    logic [W-1:0] entry_q  [C];
    logic [N-1:0] hit_chain[C+1];
    logic [W-1:0] rd_chain [C+1];

    // result fields
    olist_pkg::status_t            res_status;
    logic                          res_found;
    logic [olist_pkg::VALUE_W-1:0] res_read;
    logic [olist_pkg::POS_W-1:0]   res_fpos;

    assign req_pos   = s_tdata[olist_pkg::POS_W-1:0];
    assign req_value = s_tdata[olist_pkg::POS_W +: olist_pkg::VALUE_W];
    assign req_kind  = s_tuser;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign pos_w  = olist_pkg::CMP_W'(req_pos);
    assign cnt_w  = olist_pkg::CMP_W'(count_reg);
    assign pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
    assign full   = (count_reg == N'(C));

    // command broadcast to the cells
    always_comb
    begin
        cmd.op     = olist_pkg::CELL_HOLD;
        cmd.target = N'(pos_w - olist_pkg::CMP_W'(1));
        cmd.count  = count_reg;
        cmd.value  = W'(req_value);
        if (accept)
        begin
            case (req_kind)
                olist_pkg::KIND_INSERT:
                begin
                    if (!full)
                    begin
                        cmd.op = olist_pkg::CELL_INSERT;
                    end
                end
                olist_pkg::KIND_REPLACE:
                begin
                    if (pos_ok)
                    begin
                        cmd.op = olist_pkg::CELL_REPLACE;
                    end
                end
                olist_pkg::KIND_REMOVE:
                begin
                    if (pos_ok)
                    begin
                        cmd.op = olist_pkg::CELL_REMOVE;
                    end
                end
                default:
                begin
                    cmd.op = olist_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    assign hit_chain[0] = '0;
    assign rd_chain[0]  = '0;

    for (genvar i = 0; i < C; i++)
    begin : g_cell
        logic [W-1:0] left_entry;
        logic [W-1:0] right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = cmd.value;
        end
        else
        begin : g_mid_l
            assign left_entry = entry_q[i-1];
        end

        if (i == C - 1)
        begin : g_last
            assign right_entry = entry_q[i];
        end
        else
        begin : g_mid_r
            assign right_entry = entry_q[i+1];
        end

        olist_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .cell_idx    (N'(i)),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .hit_in      (hit_chain[i]),
            .rd_in       (rd_chain[i]),
            .entry       (entry_q[i]),
            .hit_out     (hit_chain[i+1]),
            .rd_out      (rd_chain[i+1])
        );
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        case (cmd.op)
            olist_pkg::CELL_INSERT: count_next = count_reg + N'(1);
            olist_pkg::CELL_REMOVE: count_next = count_reg - N'(1);
            default:                count_next = count_reg;
        endcase
    end

    // result fields
    always_comb
    begin
        res_status = olist_pkg::ST_OK;
        res_found  = 1'b0;
        res_read   = '0;
        res_fpos   = '0;
        case (req_kind)
            olist_pkg::KIND_INSERT:
            begin
                if (full)
                begin
                    res_status = olist_pkg::ST_FULL;
                end
            end
            olist_pkg::KIND_CONTAINS,
            olist_pkg::KIND_GET_POS:
            begin
                if (hit_chain[C] != '0)
                begin
                    res_found = 1'b1;
                    res_fpos  = olist_pkg::POS_W'(hit_chain[C]);
                end
                else
                begin
                    res_status = olist_pkg::ST_MISS;
                end
            end
            olist_pkg::KIND_GET_ELEM:
            begin
                if (pos_ok)
                begin
                    res_read = olist_pkg::VALUE_W'(rd_chain[C]);
                end
                else
                begin
                    res_status = olist_pkg::ST_MISS;
                end
            end
            olist_pkg::KIND_REPLACE,
            olist_pkg::KIND_REMOVE:
            begin
                if (!pos_ok)
                begin
                    res_status = olist_pkg::ST_MISS;
                end
            end
            default:
            begin
                res_status = olist_pkg::ST_OK;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
            m_data_next  = olist_pkg::M_TDATA_W'({olist_pkg::POS_W'(count_next),
                                                  res_fpos, res_read, res_found,
                                                  res_status});
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

endmodule
